// ===== src/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// shared types, character codes and helpers of the json string escaper
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int MAX_RES  = 8;                       // results per item
    localparam int CNT_W    = $clog2(MAX_RES + 1);     // result count width
    localparam int HOLD_W   = 3;                       // hold length width
    localparam int NDIGITS  = 3;                       // held hex digits
    localparam int DIDX_W   = $clog2(NDIGITS);

    localparam logic [HOLD_W-1:0] HOLD_MAX = HOLD_W'(5);

    localparam logic [7:0] ESC_RESET = 8'd92;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    typedef logic [7:0] byte_t;
    typedef byte_t [NDIGITS-1:0] digits_t;

    // results of one item, slot 0 goes out first
    typedef struct packed {
        byte_t [MAX_RES-1:0] bytes;
        logic [CNT_W-1:0]    count;
        logic                end_flag;
    } burst_t;

    function automatic logic is_hex(input byte_t c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

endpackage

// ===== src/jse_expand.sv =====
// ----------------------------------------------------------------------------
// jse_expand
// translates one input byte against the held escape state into its results
// ----------------------------------------------------------------------------
module jse_expand
(
    input  jse_pkg::byte_t                   in_char,
    input  logic                             in_last,
    input  jse_pkg::byte_t                   escape_char,
    input  logic [jse_pkg::HOLD_W-1:0]       hold_len,
    input  jse_pkg::digits_t                 held_digits,
    output logic [jse_pkg::HOLD_W-1:0]       hold_len_next,
    output jse_pkg::digits_t                 held_digits_next,
    output jse_pkg::burst_t                  burst
);
    import jse_pkg::*;

    logic [HOLD_W-1:0] h;
    logic              match;
    logic [HOLD_W-1:0] rel_h;
    logic              rel_dbl;
    logic              do_fresh;
    logic              tail_en;
    logic [CNT_W-1:0]  rl;
    logic [CNT_W-1:0]  sl;
    logic [CNT_W-1:0]  j;
    byte_t             lst [7];
    byte_t             rel [6];
    byte_t             fr  [2];
    byte_t             sec [2];
    logic [1:0]        fl;
    logic              fresh_hold;
    logic              special;

    // fresh byte translation
    always_comb
    begin
        special    = 1'b1;
        fresh_hold = 1'b0;
        fr[0]      = escape_char;
        fr[1]      = in_char;
        fl         = 2'd2;
        case (in_char)
            CH_NL:    fr[1] = CH_N;
            CH_CR:    fr[1] = CH_R;
            CH_TAB:   fr[1] = CH_T;
            CH_QUOTE: fr[1] = CH_QUOTE;
            default:  special = 1'b0;
        endcase
        if (!special)
        begin
            if (in_char == escape_char)
            begin
                fr[1] = escape_char;
                if (!in_last)
                begin
                    fl         = 2'd0;
                    fresh_hold = 1'b1;
                end
            end
            else if (in_char < CH_SPACE)
            begin
                fr[0] = CH_SPACE;
                fl    = 2'd1;
            end
            else
            begin
                fr[0] = in_char;
                fl    = 2'd1;
            end
        end
    end

    // hold state and release selection
    always_comb
    begin
        h                = (hold_len > HOLD_MAX) ? '0 : hold_len;
        match            = (h == HOLD_W'(1)) ? (in_char == CH_U) : is_hex(in_char);
        held_digits_next = held_digits;
        hold_len_next    = h;
        rel_h            = '0;
        rel_dbl          = 1'b0;
        do_fresh         = 1'b0;
        tail_en          = 1'b0;
        if (h == '0)
        begin
            do_fresh = 1'b1;
        end
        else if (match)
        begin
            if (h == HOLD_MAX)
            begin
                rel_h         = h;
                tail_en       = 1'b1;
                hold_len_next = '0;
            end
            else
            begin
                if (h >= HOLD_W'(2))
                    held_digits_next[DIDX_W'(h - HOLD_W'(2))] = in_char;
                hold_len_next = h + HOLD_W'(1);
                if (in_last)
                begin
                    rel_h   = h + HOLD_W'(1);
                    rel_dbl = 1'b1;
                end
            end
        end
        else
        begin
            rel_h         = h;
            rel_dbl       = 1'b1;
            hold_len_next = '0;
            do_fresh      = 1'b1;
        end
        if (do_fresh && fresh_hold)
            hold_len_next = HOLD_W'(1);
        if (in_last)
            hold_len_next = '0;
    end

    // assemble release bytes then fresh or tail bytes
    always_comb
    begin
        lst[0] = escape_char;
        lst[1] = escape_char;
        lst[2] = CH_U;
        lst[3] = held_digits_next[0];
        lst[4] = held_digits_next[1];
        lst[5] = held_digits_next[2];
        lst[6] = '0;
        for (int k = 0; k < 6; k++)
            rel[k] = (rel_dbl || k == 0) ? lst[k] : lst[k + 1];

        rl = (rel_h == '0) ? '0 : CNT_W'(rel_h) + CNT_W'(rel_dbl);
        if (tail_en)
        begin
            sec[0] = in_char;
            sec[1] = in_char;
            sl     = CNT_W'(1);
        end
        else
        begin
            sec[0] = fr[0];
            sec[1] = fr[1];
            sl     = do_fresh ? CNT_W'(fl) : '0;
        end

        burst.count    = rl + sl;
        burst.end_flag = in_last;
        for (int i = 0; i < MAX_RES; i++)
        begin
            j = CNT_W'(i) - rl;
            if (CNT_W'(i) < rl && i < 6)
                burst.bytes[i] = rel[i];
            else if (j == '0)
                burst.bytes[i] = sec[0];
            else
                burst.bytes[i] = sec[1];
        end
    end

endmodule

// ===== src/jse_obuf.sv =====
// ----------------------------------------------------------------------------
// jse_obuf
// result register that sends the results of one item one byte per cycle while out_ready is high
// ----------------------------------------------------------------------------
module jse_obuf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    input  jse_pkg::burst_t  burst,
    output logic             load_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output jse_pkg::byte_t   out_char,
    output logic             out_last,
    output logic             out_end
);
    import jse_pkg::*;

    byte_t [MAX_RES-1:0] buf_reg;
    byte_t [MAX_RES-1:0] buf_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic                end_reg;
    logic                end_next;
    logic                take;

    assign out_valid  = (rem_reg != '0);
    assign take       = out_valid && out_ready;
    assign out_last   = (rem_reg == CNT_W'(1));
    assign out_end    = out_last && end_reg;
    assign out_char   = buf_reg[0];
    assign load_ready = !out_valid || (out_last && out_ready);

    always_comb
    begin
        buf_next = buf_reg;
        rem_next = rem_reg;
        end_next = end_reg;
        if (load_valid && load_ready)
        begin
            buf_next = burst.bytes;
            rem_next = burst.count;
            end_next = burst.end_flag;
        end
        else if (take)
        begin
            buf_next = {8'h00, buf_reg[MAX_RES-1:1]};
            rem_next = rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        end_reg <= end_next;
    end

endmodule

// ===== src/json_string_escaper_top.sv =====
// ----------------------------------------------------------------------------
// json_string_escaper_top
// escapes the bytes of one json string value; while out_ready is high, one output byte per cycle
// ----------------------------------------------------------------------------
// Each input item is one byte of a string plus an end-of-string flag. The
// item first lands in an input register, is translated in one pass against
// the held escape state, and its results (zero to eight bytes) are loaded
// into a result register that sends one byte per cycle while out_ready is
// high. A plain byte yields one result byte, a newline, return, tab or quote
// yields two, and a broken or completed backslash-u sequence yields every
// byte it releases; the single output byte port sets the rate. An item that
// only extends a held escape sequence produces nothing. The input register
// takes the next item while the result register is still sending, and
// hands it over in the same cycle that the last result byte is taken.
// The escape character register resets to backslash and may only be written
// while the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module json_string_escaper_top
(
    input  logic            clk,
    input  logic            rst_n,
    // input items
    input  logic            in_valid,
    output logic            in_ready,
    input  jse_pkg::byte_t  in_char,
    input  logic            in_last,
    // result items
    output logic            out_valid,
    input  logic            out_ready,
    output jse_pkg::byte_t  out_char,
    output logic            out_last,
    output logic            out_end,
    // escape character register
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  jse_pkg::byte_t  cfg_data
);
    import jse_pkg::*;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    byte_t             in_char_reg;
    logic              in_last_reg;

    // escape state
    logic [HOLD_W-1:0] hold_len_reg;
    logic [HOLD_W-1:0] hold_len_next;
    digits_t           held_digits_reg;
    digits_t           held_digits_next;
    byte_t             escape_reg;

    burst_t            burst;
    logic              load_ready;
    logic              move;

    // item leaves the input register when the result register can take it
    assign move          = in_valid_reg && load_ready;
    assign in_ready      = !in_valid_reg || move;
    assign in_valid_next = (in_valid && in_ready) || (in_valid_reg && !move);
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            hold_len_reg <= '0;
            escape_reg   <= ESC_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (move)
                hold_len_reg <= hold_len_next;
            if (cfg_valid)
                escape_reg <= cfg_data;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_char_reg <= in_char;
            in_last_reg <= in_last;
        end
        if (move)
            held_digits_reg <= held_digits_next;
    end

    // translation of the registered item
    jse_expand u_expand
    (
        .in_char          (in_char_reg),
        .in_last          (in_last_reg),
        .escape_char      (escape_reg),
        .hold_len         (hold_len_reg),
        .held_digits      (held_digits_reg),
        .hold_len_next    (hold_len_next),
        .held_digits_next (held_digits_next),
        .burst            (burst)
    );

    // result register and byte serializer
    jse_obuf u_obuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid_reg),
        .burst      (burst),
        .load_ready (load_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .out_last   (out_last),
        .out_end    (out_end)
    );

    // hold length never leaves its legal range
    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_len_reg <= HOLD_MAX)
        else $error("hold length out of range");

    // end of string flushes the hold
    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        move && in_last_reg |=> hold_len_reg == '0)
        else $error("hold not cleared at end of string");

    // end of string byte is always the last byte of its item
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_end |-> out_last)
        else $error("end flag without last flag");

    // a held escape produces no result in the same step
    a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        move && !in_last_reg && hold_len_next > hold_len_reg |-> burst.count == '0)
        else $error("results emitted while extending hold");

endmodule

// ===== bench/json_string_escaper_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_escaper_top_tb
// self-checking bench for the json string escaper
// ----------------------------------------------------------------------------
// A short table of directed bytes runs first, covering field extremes, the
// newline, return, tab and quote escapes, complete and broken backslash-u
// sequences and end-of-string flushes. Phases of random token streams
// follow, each with its own escape character. Every accepted item runs
// through a local model of the escaper, and the bytes it predicts, or the
// typed bytes of a directed row, are compared against the output port in
// order. Both sides of the block idle and stall at random, but in the last phases.
// ----------------------------------------------------------------------------
module json_string_escaper_top_tb;

    import jse_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;   // generous run limit
    localparam int SETTLE_CYCLES = 8;        // covers the input to output latency
    localparam int PHASE_ITEMS   = 13;
    localparam int N_PHASES      = 8;
    localparam int N_DIRECTED    = 25;
    localparam int PAUSE_AT      = 10;       // item in a phase where the sender waits

    // one output byte with its flags
    typedef struct packed {
        byte_t ch;
        logic  last_flag;
        logic  end_flag;
    } esc_res_t;

    // directed row: n_typed of zero means the local model decides
    typedef struct packed {
        byte_t      ch;
        logic       last_flag;
        logic [1:0] n_typed;
        byte_t      t0;
        byte_t      t1;
    } dir_row_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    byte_t  in_char;
    logic   in_last;
    logic   out_valid;
    logic   out_ready;
    byte_t  out_char;
    logic   out_last;
    logic   out_end;
    logic   cfg_valid;
    logic   cfg_ready;
    byte_t  cfg_data;

    // idle chances in percent for the sender and the receiver
    int     snd_idle;
    int     rcv_idle;
    int     err_cnt;
    int     item_cnt;
    int unsigned cyc_cnt;

    // local copy of the escaper state
    byte_t             esc_reg;
    logic [HOLD_W-1:0] hold_cnt;
    byte_t             held_hex [NDIGITS];
    esc_res_t          escaped_bytes [MAX_RES];
    int                escaped_n;

    // bytes still owed by the block, oldest first
    esc_res_t          pending_bytes [$];

    // directed table, extremes and the escape cases with the reset escape char
    dir_row_t dir_tab [N_DIRECTED] = '{
        '{8'h00,     1'b0, 2'd1, CH_SPACE,  8'h00},     // null byte becomes a space
        '{8'hff,     1'b0, 2'd1, 8'hff,     8'h00},
        '{CH_NL,     1'b0, 2'd2, ESC_RESET, CH_N},
        '{CH_CR,     1'b0, 2'd2, ESC_RESET, CH_R},
        '{CH_TAB,    1'b0, 2'd2, ESC_RESET, CH_T},
        '{CH_QUOTE,  1'b0, 2'd2, ESC_RESET, CH_QUOTE},
        '{8'h1f,     1'b0, 2'd1, CH_SPACE,  8'h00},
        '{8'h7e,     1'b1, 2'd1, 8'h7e,     8'h00},     // plain byte ends the string
        '{ESC_RESET, 1'b0, 2'd0, 8'h00,     8'h00},     // complete sequence
        '{CH_U,      1'b0, 2'd0, 8'h00,     8'h00},
        '{"0",       1'b0, 2'd0, 8'h00,     8'h00},
        '{"a",       1'b0, 2'd0, 8'h00,     8'h00},
        '{"F",       1'b0, 2'd0, 8'h00,     8'h00},
        '{"9",       1'b0, 2'd0, 8'h00,     8'h00},
        '{ESC_RESET, 1'b0, 2'd0, 8'h00,     8'h00},     // broken after the u
        '{CH_U,      1'b0, 2'd0, 8'h00,     8'h00},
        '{"g",       1'b0, 2'd0, 8'h00,     8'h00},
        '{ESC_RESET, 1'b0, 2'd0, 8'h00,     8'h00},     // broken right after the escape
        '{"x",       1'b0, 2'd0, 8'h00,     8'h00},
        '{ESC_RESET, 1'b0, 2'd0, 8'h00,     8'h00},     // escape breaks and restarts
        '{ESC_RESET, 1'b0, 2'd0, 8'h00,     8'h00},
        '{CH_U,      1'b0, 2'd0, 8'h00,     8'h00},
        '{"A",       1'b1, 2'd0, 8'h00,     8'h00},     // string ends mid-sequence
        '{ESC_RESET, 1'b1, 2'd2, ESC_RESET, ESC_RESET}, // lone escape at the end
        '{8'h80,     1'b0, 2'd1, 8'h80,     8'h00}
    };

    json_string_escaper_top u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .out_last   (out_last),
        .out_end    (out_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // local model of the escaper
    // ------------------------------------------------------------------

    function automatic void emit_byte(input byte_t c);
        if (escaped_n < MAX_RES)
        begin
            escaped_bytes[escaped_n] = '{ch: c, last_flag: 1'b0, end_flag: 1'b0};
            escaped_n++;
        end
    endfunction

    function automatic logic hex_digit_ok(input byte_t c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F");
    endfunction

    // let go of the held escape, u and digits; doubled on a broken or cut sequence
    function automatic void release_hold(input logic doubled);
        int k;
        emit_byte(esc_reg);
        if (doubled)
            emit_byte(esc_reg);
        if (hold_cnt >= 2)
            emit_byte(CH_U);
        for (k = 2; k < int'(hold_cnt) && k < 5; k++)
            emit_byte(held_hex[k-2]);
        hold_cnt = '0;
    endfunction

    // a byte seen with nothing held
    function automatic void fresh_byte(input byte_t c, input logic last);
        if (c == CH_NL)
        begin
            emit_byte(esc_reg);
            emit_byte(CH_N);
        end
        else if (c == CH_CR)
        begin
            emit_byte(esc_reg);
            emit_byte(CH_R);
        end
        else if (c == CH_TAB)
        begin
            emit_byte(esc_reg);
            emit_byte(CH_T);
        end
        else if (c == CH_QUOTE)
        begin
            emit_byte(esc_reg);
            emit_byte(CH_QUOTE);
        end
        else if (c == esc_reg)
        begin
            if (last)
            begin
                emit_byte(esc_reg);
                emit_byte(esc_reg);
            end
            else
                hold_cnt = HOLD_W'(1);
        end
        else if (c < CH_SPACE)
            emit_byte(CH_SPACE);
        else
            emit_byte(c);
    endfunction

    function automatic void predict_escape(input byte_t c, input logic last);
        logic match;
        escaped_n = 0;
        if (hold_cnt != 0)
        begin
            match = (hold_cnt == 1) ? (c == CH_U) : hex_digit_ok(c);
            if (match)
            begin
                if (hold_cnt == HOLD_MAX)
                begin
                    release_hold(1'b0);
                    emit_byte(c);
                end
                else
                begin
                    if (hold_cnt >= 2)
                        held_hex[int'(hold_cnt) - 2] = c;
                    hold_cnt++;
                    if (last)
                        release_hold(1'b1);
                end
            end
            else
            begin
                release_hold(1'b1);
                fresh_byte(c, last);
            end
        end
        else
            fresh_byte(c, last);
        if (last)
            hold_cnt = '0;
        if (escaped_n > 0)
        begin
            escaped_bytes[escaped_n-1].last_flag = 1'b1;
            escaped_bytes[escaped_n-1].end_flag  = last;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic pick_last();
        return ($urandom_range(9) == 0);
    endfunction

    function automatic byte_t rand_hex();
        int v;
        v = $urandom_range(21);
        if (v < 10)
            return byte_t'("0" + v);
        else if (v < 16)
            return byte_t'("a" + v - 10);
        else
            return byte_t'("A" + v - 16);
    endfunction

    // offer one item, then book what it owes once it is taken
    task automatic send_item(input byte_t c, input logic last, input logic [1:0] n_typed,
                             input byte_t t0, input byte_t t1);
        int k;
        if ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        in_last  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        item_cnt++;
        // the model always runs so its state stays in step
        predict_escape(c, last);
        if (n_typed == 0)
        begin
            for (k = 0; k < escaped_n; k++)
                pending_bytes.push_back(escaped_bytes[k]);
        end
        else
        begin
            for (k = 0; k < int'(n_typed); k++)
                pending_bytes.push_back('{ch: (k == 0) ? t0 : t1,
                                         last_flag: (k == int'(n_typed) - 1),
                                         end_flag: (k == int'(n_typed) - 1) && last});
        end
    endtask

    // sender holds back until every owed byte is out
    task automatic pause_input();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_escape_char(input byte_t v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        esc_reg = v;
    endtask

    // one random token: mostly well-formed escapes and text, some noise
    task automatic send_token();
        byte_t seq [7];
        int    n;
        int    k;
        int    kind;
        int    ndig;
        logic  fin_last;
        kind     = $urandom_range(99);
        fin_last = pick_last();
        n        = 1;
        if (kind < 30)
            seq[0] = byte_t'($urandom_range(126, 32));
        else if (kind < 40)
        begin
            case ($urandom_range(3))
                0: seq[0] = CH_NL;
                1: seq[0] = CH_CR;
                2: seq[0] = CH_TAB;
                default: seq[0] = CH_QUOTE;
            endcase
        end
        else if (kind < 48)
            seq[0] = byte_t'($urandom_range(31));
        else if (kind < 56)
            seq[0] = byte_t'($urandom_range(255));
        else if (kind < 80)
        begin
            // complete backslash-u sequence
            seq[0] = esc_reg;
            seq[1] = CH_U;
            for (k = 2; k < 6; k++)
                seq[k] = rand_hex();
            n = 6;
        end
        else if (kind < 92)
        begin
            // partial sequence, broken by a random byte or cut by the string end
            ndig   = $urandom_range(3);
            seq[0] = esc_reg;
            seq[1] = CH_U;
            for (k = 0; k < ndig; k++)
                seq[2+k] = rand_hex();
            n = 2 + ndig;
            if ($urandom_range(2) == 0)
                fin_last = 1'b1;
            else
            begin
                seq[n] = byte_t'($urandom_range(255));
                n++;
            end
        end
        else
        begin
            seq[0] = esc_reg;
            seq[1] = byte_t'($urandom_range(255));
            n = 2;
        end
        for (k = 0; k < n; k++)
            send_item(seq[k], (k == n - 1) ? fin_last : 1'b0, 2'd0, 8'h00, 8'h00);
    endtask

    // ------------------------------------------------------------------
    // receiver and result check
    // ------------------------------------------------------------------

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected out item: out_char %h out_last %b out_end %b",
                       out_char, out_last, out_end);
                err_cnt++;
            end
            else
            begin
                if (out_char !== pending_bytes[0].ch)
                begin
                    $error("out_char expected %h actual %h", pending_bytes[0].ch, out_char);
                    err_cnt++;
                end
                if (out_last !== pending_bytes[0].last_flag)
                begin
                    $error("out_last expected %b actual %b",
                           pending_bytes[0].last_flag, out_last);
                    err_cnt++;
                end
                if (out_end !== pending_bytes[0].end_flag)
                begin
                    $error("out_end expected %b actual %b",
                           pending_bytes[0].end_flag, out_end);
                    err_cnt++;
                end
                void'(pending_bytes.pop_front());
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int   i;
        int   ph;
        int   start;
        logic paused;
        byte_t esc_val;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_char   = '0;
        in_last   = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        err_cnt   = 0;
        item_cnt  = 0;
        cyc_cnt   = 0;
        snd_idle  = 38;
        rcv_idle  = 50;

        esc_reg  = ESC_RESET;
        hold_cnt = '0;
        for (i = 0; i < NDIGITS; i++)
            held_hex[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with the escape char left at its reset value
        for (i = 0; i < N_DIRECTED; i++)
            send_item(dir_tab[i].ch, dir_tab[i].last_flag, dir_tab[i].n_typed,
                      dir_tab[i].t0, dir_tab[i].t1);
        pause_input();
        repeat (SETTLE_CYCLES) @(posedge clk);

        // random phases, each under its own escape char
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            // receiver idles more first, then the sender, then neither idles
            if (ph < 3)
            begin
                snd_idle = 38;
                rcv_idle = 50;
            end
            else if (ph < 6)
            begin
                snd_idle = 50;
                rcv_idle = 38;
            end
            else
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end

            case (ph)
                0: esc_val = ESC_RESET;
                1: esc_val = 8'h00;
                2: esc_val = 8'hff;
                3: esc_val = CH_U;          // u as escape, held u bytes go out literally
                4: esc_val = "a";           // hex digit as escape
                5: esc_val = CH_NL;         // newline rule beats the escape rule
                6: esc_val = CH_QUOTE;
                default: esc_val = byte_t'($urandom_range(255));
            endcase
            // may land while a sequence is held from the previous phase
            write_escape_char(esc_val);

            start  = item_cnt;
            paused = 1'b0;
            while (item_cnt - start < PHASE_ITEMS)
            begin
                if (!paused && item_cnt - start >= PAUSE_AT)
                begin
                    pause_input();
                    paused = 1'b1;
                end
                send_token();
            end

            // even phases leave a sequence held across the register write
            if (ph % 2 == 0)
            begin
                send_item(esc_reg, 1'b0, 2'd0, 8'h00, 8'h00);
                send_item(CH_U, 1'b0, 2'd0, 8'h00, 8'h00);
                send_item(rand_hex(), 1'b0, 2'd0, 8'h00, 8'h00);
            end
            pause_input();
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        // flush anything still held so the last bytes are checked too
        send_item(8'h41, 1'b1, 2'd0, 8'h00, 8'h00);
        pause_input();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
src/jse_pkg.sv
src/jse_expand.sv
src/jse_obuf.sv
src/json_string_escaper_top.sv
bench/json_string_escaper_top_tb.sv
